// ===== src/positional_list_engine_top_defines.svh =====
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// Checked only while out of reset.
`define PLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== src/ple_pkg.sv =====
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [2:0] OP_APPEND   = 3'd0;
    localparam logic [2:0] OP_PREPEND  = 3'd1;
    localparam logic [2:0] OP_INSERT   = 3'd2;
    localparam logic [2:0] OP_REMOVE   = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;
    localparam logic [2:0] OP_CONTAINS = 3'd5;
    localparam logic [2:0] OP_REVERSE  = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] RA_PTR    = 2'd0;
    localparam logic [1:0] RA_PTR_M1 = 2'd1;
    localparam logic [1:0] RA_PTR_P1 = 2'd2;

    localparam logic [2:0] WR_NONE    = 3'd0;
    localparam logic [2:0] WR_PTR_A   = 3'd1;
    localparam logic [2:0] WR_PTR_B   = 3'd2;
    localparam logic [2:0] WR_TGT_VAL = 3'd3;
    localparam logic [2:0] WR_HI_A    = 3'd4;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] item_value;
        logic [7:0]         position;
    } t_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic               found;
        logic [6:0]         length;
    } t_result;

    typedef struct packed {
        logic       load;
        logic       setup;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic [2:0] wr_sel;
        logic       ptr_inc;
        logic       ptr_dec;
        logic       hi_dec;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       capture;
        logic       set_found;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       fail;
        logic       ins_more;
        logic       rem_more;
        logic       scan_more;
        logic       lohi_more;
        logic       match;
    } t_dp_stat;

endpackage

// ===== src/ple_datapath.sv =====
`include "positional_list_engine_top_defines.svh"

module ple_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ple_pkg::t_item   i_item,
    input  ple_pkg::t_dp_cmd i_cmd,
    output ple_pkg::t_dp_stat o_stat,
    output ple_pkg::t_result o_result
);
    import ple_pkg::*;

    logic [31:0]      r_mem [CAPACITY];
    logic [31:0]      r_rd_a;
    logic [31:0]      r_rd_b;
    t_item            r_item;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_tgt;
    logic [CNT_W-1:0] r_hi;
    logic [1:0]       r_status;
    logic             r_found;
    logic [31:0]      r_rv;

    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    logic [CNT_W-1:0] w_pos_m1;
    logic [CNT_W-1:0] w_ptr_m1;
    logic [CNT_W-1:0] w_ptr_p1;
    logic [CNT_W:0]   w_ptr_p1_wide;
    logic             w_ins_bad;
    logic             w_acc_bad;
    logic             w_full;
    logic [1:0]       w_status;
    logic [IDX_W-1:0] w_raddr_a;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [31:0]      w_wdata;

    assign w_pos         = CMP_W'(r_item.position);
    assign w_cnt         = CMP_W'(r_count);
    assign w_pos_m1      = CNT_W'(w_pos - CMP_W'(1));
    assign w_ptr_m1      = r_ptr - CNT_W'(1);
    assign w_ptr_p1      = r_ptr + CNT_W'(1);
    assign w_ptr_p1_wide = {1'b0, r_ptr} + (CNT_W+1)'(1);
    assign w_ins_bad     = (w_pos == '0) || (w_pos > w_cnt + CMP_W'(1));
    assign w_acc_bad     = (w_pos == '0) || (w_pos > w_cnt);
    assign w_full        = (r_count == CAP_CNT);

    always_comb begin
        w_status = ST_OK;
        priority if (r_item.operation == OP_INSERT) begin
            if (w_ins_bad) begin
                w_status = ST_RANGE;
            end else if (w_full) begin
                w_status = ST_FULL;
            end
        end else if (r_item.operation == OP_APPEND || r_item.operation == OP_PREPEND) begin
            if (w_full) begin
                w_status = ST_FULL;
            end
        end else if (r_item.operation == OP_REMOVE || r_item.operation == OP_READ) begin
            if (w_acc_bad) begin
                w_status = ST_RANGE;
            end
        end else begin
            w_status = ST_OK;
        end
    end

    assign o_stat.op        = r_item.operation;
    assign o_stat.fail      = (w_status != ST_OK);
    assign o_stat.ins_more  = (r_ptr > r_tgt);
    assign o_stat.rem_more  = (w_ptr_p1_wide < {1'b0, r_count});
    assign o_stat.scan_more = (r_ptr < r_count);
    assign o_stat.lohi_more = (r_ptr < r_hi);
    assign o_stat.match     = (r_rd_a == r_item.item_value);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RA_PTR_M1: w_raddr_a = w_ptr_m1[IDX_W-1:0];
            RA_PTR_P1: w_raddr_a = w_ptr_p1[IDX_W-1:0];
            default:   w_raddr_a = r_ptr[IDX_W-1:0];
        endcase
    end

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_ptr[IDX_W-1:0];
        w_wdata = r_rd_a;
        unique case (i_cmd.wr_sel)
            WR_PTR_A: begin
                w_waddr = r_ptr[IDX_W-1:0];
                w_wdata = r_rd_a;
            end
            WR_PTR_B: begin
                w_waddr = r_ptr[IDX_W-1:0];
                w_wdata = r_rd_b;
            end
            WR_TGT_VAL: begin
                w_waddr = r_tgt[IDX_W-1:0];
                w_wdata = r_item.item_value;
            end
            WR_HI_A: begin
                w_waddr = r_hi[IDX_W-1:0];
                w_wdata = r_rd_a;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem[w_raddr_a];
            r_rd_b <= r_mem[r_hi[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.setup) begin
            r_status <= w_status;
            r_found  <= 1'b0;
            r_rv     <= '0;
            r_hi     <= (r_count == '0) ? '0 : r_count - CNT_W'(1);
            unique case (r_item.operation)
                OP_APPEND: begin
                    r_ptr <= r_count;
                    r_tgt <= r_count;
                end
                OP_PREPEND: begin
                    r_ptr <= r_count;
                    r_tgt <= '0;
                end
                OP_INSERT: begin
                    r_ptr <= r_count;
                    r_tgt <= w_pos_m1;
                end
                OP_REMOVE, OP_READ: begin
                    r_ptr <= w_pos_m1;
                    r_tgt <= r_count;
                end
                default: begin
                    r_ptr <= '0;
                    r_tgt <= r_count;
                end
            endcase
        end else begin
            if (i_cmd.ptr_inc) begin
                r_ptr <= w_ptr_p1;
            end else if (i_cmd.ptr_dec) begin
                r_ptr <= w_ptr_m1;
            end
            if (i_cmd.hi_dec) begin
                r_hi <= r_hi - CNT_W'(1);
            end
            if (i_cmd.capture) begin
                r_rv <= r_rd_a;
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
        end
    end

    assign o_result.read_value = r_rv;
    assign o_result.status     = r_status;
    assign o_result.found      = r_found;
    assign o_result.length     = 7'(r_count);

    `PLE_ASSERT(a_count_bound, r_count <= CAP_CNT, "list length above capacity")
    `PLE_ASSERT(a_put_not_full, (i_cmd.wr_sel == WR_TGT_VAL) |-> !w_full, "put into full list")
    `PLE_ASSERT(a_swap_order, (i_cmd.wr_sel == WR_HI_A) |-> (r_ptr < r_hi), "swap past midpoint")

endmodule

// ===== src/ple_ctrl.sv =====
`include "positional_list_engine_top_defines.svh"

module ple_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    input  ple_pkg::t_dp_stat i_stat,
    output ple_pkg::t_dp_cmd  o_cmd
);
    import ple_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_INS_RD   = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_INS_PUT  = 4'd4;
    localparam logic [3:0] S_REM_RD   = 4'd5;
    localparam logic [3:0] S_REM_WR   = 4'd6;
    localparam logic [3:0] S_RD_ADDR  = 4'd7;
    localparam logic [3:0] S_RD_WAIT  = 4'd8;
    localparam logic [3:0] S_SCAN_RD  = 4'd9;
    localparam logic [3:0] S_SCAN_CMP = 4'd10;
    localparam logic [3:0] S_REV_RD   = 4'd11;
    localparam logic [3:0] S_REV_WLO  = 4'd12;
    localparam logic [3:0] S_REV_WHI  = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RA_PTR;
        o_cmd.wr_sel = WR_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.setup = 1'b1;
                if (i_stat.fail) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_stat.op)
                        OP_APPEND, OP_PREPEND, OP_INSERT: n_state = S_INS_RD;
                        OP_REMOVE:                        n_state = S_REM_RD;
                        OP_READ:                          n_state = S_RD_ADDR;
                        OP_CONTAINS:                      n_state = S_SCAN_RD;
                        OP_REVERSE:                       n_state = S_REV_RD;
                        default:                          n_state = S_DONE;
                    endcase
                end
            end
            S_INS_RD: begin
                if (i_stat.ins_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_PTR_M1;
                    n_state      = S_INS_WR;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_sel  = WR_PTR_A;
                o_cmd.ptr_dec = 1'b1;
                n_state       = S_INS_RD;
            end
            S_INS_PUT: begin
                o_cmd.wr_sel  = WR_TGT_VAL;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_DONE;
            end
            S_REM_RD: begin
                if (i_stat.rem_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_PTR_P1;
                    n_state      = S_REM_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_REM_WR: begin
                o_cmd.wr_sel  = WR_PTR_A;
                o_cmd.ptr_inc = 1'b1;
                n_state       = S_REM_RD;
            end
            S_RD_ADDR: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                o_cmd.capture = 1'b1;
                n_state       = S_DONE;
            end
            S_SCAN_RD: begin
                if (i_stat.scan_more) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_SCAN_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.match) begin
                    o_cmd.set_found = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_REV_RD: begin
                if (i_stat.lohi_more) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_REV_WLO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REV_WLO: begin
                o_cmd.wr_sel = WR_PTR_B;
                n_state      = S_REV_WHI;
            end
            S_REV_WHI: begin
                o_cmd.wr_sel  = WR_HI_A;
                o_cmd.ptr_inc = 1'b1;
                o_cmd.hi_dec  = 1'b1;
                n_state       = S_REV_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PLE_ASSERT(a_done_single, o_done |=> !o_done, "result strobe longer than one cycle")
    `PLE_ASSERT(a_busy_from_start, $rose(o_busy) |-> $past(i_start), "busy without start")
    `PLE_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE), "controller not idle after reset")

endmodule

// ===== src/positional_list_engine_top.sv =====
// Ordered list of up to CAPACITY signed 32-bit values, held in a single-write, dual-read
// memory with registered reads. An operation is transferred when start is high and busy
// is low; its result appears on o_result for exactly one cycle with o_done high, and busy
// drops the cycle after that. The list is shifted one entry at a time through the memory
// port: append writes at the end; prepend and insert move the entries from the position
// on up by one, then write (prepend at position 1); remove moves later entries down one;
// read is one registered read; contains scans from the first entry to a match or the end;
// reverse swaps pairs from both ends inward; a rejected or unused code goes to o_done.
// The receiver cannot stall: o_result keeps a result only until the next operation.
module positional_list_engine_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ple_pkg::t_item   i_item,
    output logic             o_done,
    output ple_pkg::t_result o_result
);
    import ple_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ple_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ple_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

endmodule
